FILE: hw/rtl/grcl_pkg.sv
// Package for the gondola rate control law: control modes, register indexes,
// fixed-point limits and the saturating Q16.16 helpers.
// Depends on nothing; imported by gondola_rate_control_law.
package grcl_pkg;

    typedef enum logic [1:0] {
        MODE_POINT   = 2'd0,
        MODE_SPIN    = 2'd1,
        MODE_SCAN    = 2'd2,
        MODE_INVALID = 2'd3
    } ctrl_mode_t;

    typedef enum logic [2:0] {
        CFG_CONTROL_MODE          = 3'd0,
        CFG_SPIN_WHEEL_ERROR_GAIN = 3'd1,
        CFG_SPIN_WHEEL_ACCEL_GAIN = 3'd2,
        CFG_SPIN_PIVOT_ERROR_GAIN = 3'd3,
        CFG_SPIN_PIVOT_WHEEL_GAIN = 3'd4,
        CFG_SCAN_WHEEL_ERROR_GAIN = 3'd5,
        CFG_SCAN_PIVOT_ERROR_GAIN = 3'd6,
        CFG_SCAN_PIVOT_WHEEL_GAIN = 3'd7
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned Q_W         = 32;
    localparam int unsigned PIVOT_W     = 23;

    // 900 dps and 45 dps in Q16.16.
    localparam logic [Q_W:0]          WHEEL_SPEED_LIMIT = 33'd58982400;
    localparam logic [Q_W:0]          GONDOLA_LIMIT     = 33'd2949120;
    localparam logic signed [Q_W-1:0] PIVOT_LIMIT       = 32'sd2949120;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    // Saturate a 33-bit sum or difference back to 32 bits.
    function automatic logic signed [Q_W-1:0] sat33(input logic signed [Q_W:0] v);
        logic signed [Q_W-1:0] r;
        if (v[Q_W] != v[Q_W-1])
        begin
            r = v[Q_W] ? Q_MIN : Q_MAX;
        end
        else
        begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] qadd(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        return sat33({a[Q_W-1], a} + {b[Q_W-1], b});
    endfunction

    function automatic logic signed [Q_W-1:0] qsub(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        return sat33({a[Q_W-1], a} - {b[Q_W-1], b});
    endfunction

    // Drop the 16 fraction bits of a full product (arithmetic shift rounds
    // toward minus infinity) and saturate the remaining 48 bits to 32.
    function automatic logic signed [Q_W-1:0] qscale(input logic signed [2*Q_W-1:0] p);
        logic signed [2*Q_W-17:0] q;
        logic signed [Q_W-1:0]    r;
        q = p[2*Q_W-1:16];
        if (q > 48'(Q_MAX))
        begin
            r = Q_MAX;
        end
        else if (q < 48'(Q_MIN))
        begin
            r = Q_MIN;
        end
        else
        begin
            r = q[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/gondola_rate_control_law.sv
// Gondola rate control law: a five-stage pipeline from the sensor word to the
// wheel current and pivot rate requests.
// Depends on grcl_pkg for modes, register indexes and Q16.16 helpers.
//
// Usage:
// - The input channel (in_valid/in_ready) carries one sensor word: gondola
//   rate, target rate, wheel rate and gondola acceleration, signed Q16.16.
// - The output channel (out_valid/out_ready) returns exactly one result word
//   per input word, in order: pivot rate request, wheel current request and
//   three status flags.
// - The configuration channel (cfg_valid/cfg_ready) writes the control mode
//   and seven gains by index. It is always ready. Write it only while no
//   word is in flight; gains are read live by the multiplier stage.
// - Each accepted word passes through all five register stages before its
//   result is shown with out_valid. The block accepts one word every cycle:
//   each of the five register stages holds one word and all of them advance
//   together, so only a stalling receiver slows it down.
// - When the receiver stalls with a word held in the output register, the
//   whole pipeline freezes and in_ready drops; nothing is lost or repeated.
// - Reset clears every valid bit, sets the control mode to point and clears
//   all gains to zero.
module gondola_rate_control_law #(
    parameter int MAX_WHEEL_CURRENT_Q16 = 196608
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [grcl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [grcl_pkg::Q_W-1:0]            cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [grcl_pkg::Q_W-1:0]     gondola_rate,
    input  logic signed [grcl_pkg::Q_W-1:0]     target_rate,
    input  logic signed [grcl_pkg::Q_W-1:0]     wheel_rate,
    input  logic signed [grcl_pkg::Q_W-1:0]     gondola_accel,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [grcl_pkg::PIVOT_W-1:0] pivot_rate_request,
    output logic signed [grcl_pkg::Q_W-1:0]     wheel_current_request,
    output logic                                wheel_overspeed_cut,
    output logic                                gondola_overspeed,
    output logic                                invalid_mode
);
    import grcl_pkg::*;

    // The current limit is taken as zero when the parameter is negative.
    localparam logic signed [Q_W-1:0] CUR_LIM =
        (MAX_WHEEL_CURRENT_Q16 < 0) ? '0 : Q_W'(MAX_WHEEL_CURRENT_Q16);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    ctrl_mode_t            control_mode_reg;
    logic signed [Q_W-1:0] spin_wheel_error_gain_reg;
    logic signed [Q_W-1:0] spin_wheel_accel_gain_reg;
    logic signed [Q_W-1:0] spin_pivot_error_gain_reg;
    logic signed [Q_W-1:0] spin_pivot_wheel_gain_reg;
    logic signed [Q_W-1:0] scan_wheel_error_gain_reg;
    logic signed [Q_W-1:0] scan_pivot_error_gain_reg;
    logic signed [Q_W-1:0] scan_pivot_wheel_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_mode_reg          <= MODE_POINT;
            spin_wheel_error_gain_reg <= '0;
            spin_wheel_accel_gain_reg <= '0;
            spin_pivot_error_gain_reg <= '0;
            spin_pivot_wheel_gain_reg <= '0;
            scan_wheel_error_gain_reg <= '0;
            scan_pivot_error_gain_reg <= '0;
            scan_pivot_wheel_gain_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CONTROL_MODE:          control_mode_reg <= ctrl_mode_t'(cfg_data[1:0]);
                CFG_SPIN_WHEEL_ERROR_GAIN: spin_wheel_error_gain_reg <= cfg_data;
                CFG_SPIN_WHEEL_ACCEL_GAIN: spin_wheel_accel_gain_reg <= cfg_data;
                CFG_SPIN_PIVOT_ERROR_GAIN: spin_pivot_error_gain_reg <= cfg_data;
                CFG_SPIN_PIVOT_WHEEL_GAIN: spin_pivot_wheel_gain_reg <= cfg_data;
                CFG_SCAN_WHEEL_ERROR_GAIN: scan_wheel_error_gain_reg <= cfg_data;
                CFG_SCAN_PIVOT_ERROR_GAIN: scan_pivot_error_gain_reg <= cfg_data;
                CFG_SCAN_PIVOT_WHEEL_GAIN: scan_pivot_wheel_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. Every stage moves together whenever the output
    // register is empty or its word is being taken this cycle.
    // ------------------------------------------------------------------
    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: rate error and mode capture.
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] err1_next;
    logic signed [Q_W-1:0] err1_reg, g1_reg, w1_reg, a1_reg;
    ctrl_mode_t            mode1_reg;

    assign err1_next = qsub(gondola_rate, target_rate);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            err1_reg  <= err1_next;
            g1_reg    <= gondola_rate;
            w1_reg    <= wheel_rate;
            a1_reg    <= gondola_accel;
            mode1_reg <= control_mode_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: four full-width products. Scan mode swaps in its own gains.
    //   m1: wheel error gain * error      m2: wheel accel gain * accel
    //   m3: pivot error gain * error      m4: pivot wheel gain * wheel rate
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0]   k1, k3, k4;
    logic signed [2*Q_W-1:0] m1_next, m2_next, m3_next, m4_next;
    logic signed [2*Q_W-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [Q_W-1:0]   g2_reg, w2_reg;
    ctrl_mode_t              mode2_reg;

    always_comb
    begin
        if (mode1_reg == MODE_SCAN)
        begin
            k1 = scan_wheel_error_gain_reg;
            k3 = scan_pivot_error_gain_reg;
            k4 = scan_pivot_wheel_gain_reg;
        end
        else
        begin
            k1 = spin_wheel_error_gain_reg;
            k3 = spin_pivot_error_gain_reg;
            k4 = spin_pivot_wheel_gain_reg;
        end
    end

    assign m1_next = 64'(k1) * 64'(err1_reg);
    assign m2_next = 64'(spin_wheel_accel_gain_reg) * 64'(a1_reg);
    assign m3_next = 64'(k3) * 64'(err1_reg);
    assign m4_next = 64'(k4) * 64'(w1_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            m3_reg    <= m3_next;
            m4_reg    <= m4_next;
            g2_reg    <= g1_reg;
            w2_reg    <= w1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: floor to Q16.16 and saturate each product.
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] q1_reg, q2_reg, q3_reg, q4_reg, g3_reg, w3_reg;
    ctrl_mode_t            mode3_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q1_reg    <= qscale(m1_reg);
            q2_reg    <= qscale(m2_reg);
            q3_reg    <= qscale(m3_reg);
            q4_reg    <= qscale(m4_reg);
            g3_reg    <= g2_reg;
            w3_reg    <= w2_reg;
            mode3_reg <= mode2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: mode-dependent saturating sums.
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] cur4_next, piv4_next;
    logic                  inval4_next;
    logic signed [Q_W-1:0] cur4_reg, piv4_reg, g4_reg, w4_reg;
    logic                  inval4_reg;

    always_comb
    begin
        cur4_next   = '0;
        piv4_next   = '0;
        inval4_next = 1'b0;
        case (mode3_reg)
            MODE_POINT:
            begin
                cur4_next = q1_reg;
                piv4_next = q4_reg;
            end
            MODE_SPIN:
            begin
                cur4_next = qadd(q1_reg, q2_reg);
                piv4_next = qsub(qadd(q3_reg, q4_reg), g3_reg);
            end
            MODE_SCAN:
            begin
                cur4_next = q1_reg;
                piv4_next = qadd(qadd(q4_reg, g3_reg), q3_reg);
            end
            default:
            begin
                inval4_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cur4_reg   <= cur4_next;
            piv4_reg   <= piv4_next;
            inval4_reg <= inval4_next;
            g4_reg     <= g3_reg;
            w4_reg     <= w3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: overspeed cuts, clamps, output register.
    // ------------------------------------------------------------------
    logic [Q_W:0]          abs_w, abs_g;
    logic                  wcut, gover;
    logic signed [Q_W-1:0] cur_cut, cur_clamped, piv_clamped;
    logic signed [Q_W-1:0] cur_out, piv_out;

    logic signed [PIVOT_W-1:0] pivot_reg;
    logic signed [Q_W-1:0]     current_reg;
    logic                      wcut_reg, gover_reg, inval_reg;

    always_comb
    begin
        abs_w = w4_reg[Q_W-1] ? -{w4_reg[Q_W-1], w4_reg} : {1'b0, w4_reg};
        abs_g = g4_reg[Q_W-1] ? -{g4_reg[Q_W-1], g4_reg} : {1'b0, g4_reg};

        // Cut the current when a fast wheel would be pushed further still.
        wcut = (abs_w > WHEEL_SPEED_LIMIT) &&
               (((w4_reg > 0) && (cur4_reg > 0)) || ((w4_reg < 0) && (cur4_reg < 0)));
        cur_cut = wcut ? '0 : cur4_reg;

        if (cur_cut > CUR_LIM)
        begin
            cur_clamped = CUR_LIM;
        end
        else if (cur_cut < -CUR_LIM)
        begin
            cur_clamped = -CUR_LIM;
        end
        else
        begin
            cur_clamped = cur_cut;
        end

        if (piv4_reg > PIVOT_LIMIT)
        begin
            piv_clamped = PIVOT_LIMIT;
        end
        else if (piv4_reg < -PIVOT_LIMIT)
        begin
            piv_clamped = -PIVOT_LIMIT;
        end
        else
        begin
            piv_clamped = piv4_reg;
        end

        // A gondola spinning too fast zeroes both requests.
        gover   = abs_g > GONDOLA_LIMIT;
        cur_out = gover ? '0 : cur_clamped;
        piv_out = gover ? '0 : piv_clamped;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pivot_reg   <= piv_out[PIVOT_W-1:0];
            current_reg <= cur_out;
            wcut_reg    <= wcut;
            gover_reg   <= gover;
            inval_reg   <= inval4_reg;
        end
    end

    assign out_valid             = out_valid_reg;
    assign pivot_rate_request    = pivot_reg;
    assign wheel_current_request = current_reg;
    assign wheel_overspeed_cut   = wcut_reg;
    assign gondola_overspeed     = gover_reg;
    assign invalid_mode          = inval_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid_mode |-> pivot_rate_request == '0 &&
                                      wheel_current_request == '0)
        else $error("invalid mode word carries a nonzero request");

    a_gover_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gondola_overspeed |-> pivot_rate_request == '0 &&
                                           wheel_current_request == '0)
        else $error("gondola overspeed word carries a nonzero request");

    a_wcut_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wheel_overspeed_cut |-> wheel_current_request == '0)
        else $error("wheel overspeed cut word carries a nonzero current");

    a_current_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> wheel_current_request <= CUR_LIM &&
                      wheel_current_request >= -CUR_LIM)
        else $error("wheel current request outside the limit");

    a_pivot_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> Q_W'(pivot_rate_request) <= PIVOT_LIMIT &&
                      Q_W'(pivot_rate_request) >= -PIVOT_LIMIT)
        else $error("pivot rate request outside 45 dps");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(v4_reg) && $stable(cur4_reg))
        else $error("pipeline moved while the output was stalled");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for gondola_rate_control_law: directed and random sensor words,
// a cycle-free predictor of both requests and flags, and an in-order result checker.
// Depends on grcl_pkg and gondola_rate_control_law.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import grcl_pkg::*;

    // Q16.16 scaling and the limits of the control law.
    localparam int     ONE_DPS       = 65536;
    localparam longint CURRENT_LIMIT = 196608;
    localparam longint WHEEL_FAST    = 64'sd900 * 65536;
    localparam longint GONDOLA_FAST  = 64'sd45 * 65536;
    localparam longint PIVOT_MAX     = 64'sd45 * 65536;
    localparam longint WORD_MAX      = 64'sd2147483647;
    localparam longint WORD_MIN      = -64'sd2147483648;
    // Cycles to let pass after the last result before touching registers or ending.
    localparam int     DRAIN_CYCLES  = 12;

    typedef struct {
        logic signed [31:0] gondola;
        logic signed [31:0] target;
        logic signed [31:0] wheel;
        logic signed [31:0] accel;
    } sensor_word_t;

    typedef struct {
        logic signed [22:0] pivot;
        logic signed [31:0] current;
        logic               wheel_cut;
        logic               gondola_over;
        logic               bad_mode;
    } command_word_t;

    typedef logic signed [31:0] gain_set_t [1:7];

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] gondola_rate = '0;
    logic signed [31:0] target_rate = '0;
    logic signed [31:0] wheel_rate = '0;
    logic signed [31:0] gondola_accel = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [22:0] pivot_rate_request;
    logic signed [31:0] wheel_current_request;
    logic               wheel_overspeed_cut;
    logic               gondola_overspeed;
    logic               invalid_mode;

    // Shadow of the register file as the predictor sees it.
    ctrl_mode_t         mode_q = MODE_POINT;
    gain_set_t          gain_q = '{default: '0};

    command_word_t      pending_cmds[$];
    int                 fail_count = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct = 0;
    int                 hold_req = 0;
    int                 hold_left = 0;
    int unsigned        phase_seq = 0;

    gondola_rate_control_law #(
        .MAX_WHEEL_CURRENT_Q16(int'(CURRENT_LIMIT))
    ) u_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .gondola_rate          (gondola_rate),
        .target_rate           (target_rate),
        .wheel_rate            (wheel_rate),
        .gondola_accel         (gondola_accel),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .pivot_rate_request    (pivot_rate_request),
        .wheel_current_request (wheel_current_request),
        .wheel_overspeed_cut   (wheel_overspeed_cut),
        .gondola_overspeed     (gondola_overspeed),
        .invalid_mode          (invalid_mode)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the control law, kept independent of the
    // package helpers. Everything is widened to 64 bits and saturated back.
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] clip_word(input longint v);
        if (v > WORD_MAX)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < WORD_MIN)
        begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    // The arithmetic shift of the exact product rounds toward minus infinity.
    function automatic logic signed [31:0] q_mult(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return clip_word(prod >>> 16);
    endfunction

    function automatic logic signed [31:0] q_sum(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return clip_word(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [31:0] q_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return clip_word(longint'(a) - longint'(b));
    endfunction

    // Work out the wheel current and pivot rate requests for one sensor word
    // under the current mode and gains.
    function automatic command_word_t compute_commands(input sensor_word_t s);
        command_word_t      r;
        logic signed [31:0] err;
        logic signed [31:0] cur;
        logic signed [31:0] piv;
        longint             wmag;
        longint             gmag;
        r   = '{default: '0};
        err = q_diff(s.gondola, s.target);
        cur = '0;
        piv = '0;
        case (mode_q)
            MODE_POINT:
            begin
                cur = q_mult(gain_q[CFG_SPIN_WHEEL_ERROR_GAIN], err);
                piv = q_mult(gain_q[CFG_SPIN_PIVOT_WHEEL_GAIN], s.wheel);
            end
            MODE_SPIN:
            begin
                piv = q_diff(q_sum(q_mult(gain_q[CFG_SPIN_PIVOT_ERROR_GAIN], err),
                                   q_mult(gain_q[CFG_SPIN_PIVOT_WHEEL_GAIN], s.wheel)),
                             s.gondola);
                cur = q_sum(q_mult(gain_q[CFG_SPIN_WHEEL_ERROR_GAIN], err),
                            q_mult(gain_q[CFG_SPIN_WHEEL_ACCEL_GAIN], s.accel));
            end
            MODE_SCAN:
            begin
                cur = q_mult(gain_q[CFG_SCAN_WHEEL_ERROR_GAIN], err);
                // Summation order matters because every partial sum saturates.
                piv = q_sum(q_sum(q_mult(gain_q[CFG_SCAN_PIVOT_WHEEL_GAIN], s.wheel),
                                  s.gondola),
                            q_mult(gain_q[CFG_SCAN_PIVOT_ERROR_GAIN], err));
            end
            default:
            begin
                r.bad_mode = 1'b1;
            end
        endcase

        // A fast wheel is not pushed further in the direction it already spins.
        wmag = (s.wheel < 0) ? -longint'(s.wheel) : longint'(s.wheel);
        if (wmag > WHEEL_FAST && ((s.wheel > 0 && cur > 0) || (s.wheel < 0 && cur < 0)))
        begin
            cur         = '0;
            r.wheel_cut = 1'b1;
        end

        if (longint'(cur) > CURRENT_LIMIT)
        begin
            cur = 32'(CURRENT_LIMIT);
        end
        else if (longint'(cur) < -CURRENT_LIMIT)
        begin
            cur = 32'(-CURRENT_LIMIT);
        end

        if (longint'(piv) > PIVOT_MAX)
        begin
            piv = 32'(PIVOT_MAX);
        end
        else if (longint'(piv) < -PIVOT_MAX)
        begin
            piv = 32'(-PIVOT_MAX);
        end

        // A gondola spinning too fast overrides both requests.
        gmag = (s.gondola < 0) ? -longint'(s.gondola) : longint'(s.gondola);
        if (gmag > GONDOLA_FAST)
        begin
            cur            = '0;
            piv            = '0;
            r.gondola_over = 1'b1;
        end

        r.pivot   = piv[22:0];
        r.current = cur;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random value sources.
    // ------------------------------------------------------------------
    function automatic sensor_word_t make_word(input logic signed [31:0] g,
                                               input logic signed [31:0] t,
                                               input logic signed [31:0] w,
                                               input logic signed [31:0] a);
        sensor_word_t s;
        s.gondola = g;
        s.target  = t;
        s.wheel   = w;
        s.accel   = a;
        return s;
    endfunction

    // Mostly physically plausible rates within +-span_dps, with a share of
    // extremes and fully random words so that every bit toggles.
    function automatic logic signed [31:0] pick_rate(input int unsigned span_dps);
        int unsigned roll;
        longint      span;
        roll = $urandom_range(99);
        span = longint'(span_dps) * ONE_DPS;
        if (roll < 6)
        begin
            case ($urandom_range(4))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sd0;
                3: return 32'sd1;
                default: return -32'sd1;
            endcase
        end
        if (roll < 14)
        begin
            return $urandom;
        end
        return 32'(longint'($urandom_range(32'(2 * span))) - span);
    endfunction

    // Values right at a magnitude threshold and one LSB past it.
    function automatic logic signed [31:0] pick_threshold(input longint lim);
        case ($urandom_range(3))
            0: return 32'(lim);
            1: return 32'(lim + 1);
            2: return 32'(-lim);
            default: return 32'(-lim - 1);
        endcase
    endfunction

    function automatic sensor_word_t random_word();
        sensor_word_t s;
        s.gondola = ($urandom_range(9) == 0) ? pick_threshold(GONDOLA_FAST) : pick_rate(50);
        s.target  = pick_rate(50);
        s.wheel   = ($urandom_range(9) == 0) ? pick_threshold(WHEEL_FAST) : pick_rate(1200);
        s.accel   = pick_rate(100);
        return s;
    endfunction

    // Gains spread over many binary orders so that some outputs stay inside
    // their limits and others saturate.
    function automatic logic signed [31:0] pick_gain();
        int unsigned roll;
        longint      span;
        roll = $urandom_range(99);
        span = longint'(1) << $urandom_range(8, 20);
        if (roll < 6)
        begin
            return 32'sh8000_0000;
        end
        if (roll < 12)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (roll < 16)
        begin
            return 32'sd0;
        end
        if (roll < 20)
        begin
            return $urandom;
        end
        return 32'(longint'($urandom_range(32'(2 * span))) - span);
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks. Every call starts right after a rising edge.
    // ------------------------------------------------------------------

    // Offer one sensor word, with a random gap in front of it. Valid is left
    // high afterwards so back-to-back words keep it asserted.
    task automatic send_word(input sensor_word_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        gondola_rate  <= s.gondola;
        target_rate   <= s.target;
        wheel_rate    <= s.wheel;
        gondola_accel <= s.accel;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_cmds.push_back(compute_commands(s));
    endtask

    // Stop offering words and wait until every result has been taken.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the mode register and all seven gains, one word per handshake.
    task automatic load_settings(input logic [31:0] mode_word, input gain_set_t gains);
        cfg_index_t idx;
        for (int i = 0; i < 8; i++)
        begin
            idx       = cfg_index_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (idx == CFG_CONTROL_MODE) ? mode_word : 32'(gains[i]);
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            if (idx == CFG_CONTROL_MODE)
            begin
                // Only the two low bits of the written word select the mode.
                mode_q = ctrl_mode_t'(mode_word[1:0]);
            end
            else
            begin
                gain_q[i] = gains[i];
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Drain, then program the next setting. Modes rotate with the phase count,
    // and every so often all gains sit at one extreme.
    task automatic next_setting();
        gain_set_t   gains;
        logic [31:0] mode_word;
        wait_idle();
        for (int i = 1; i <= 7; i++)
        begin
            case (phase_seq % 6)
                4: gains[i] = 32'sh7FFF_FFFF;
                5: gains[i] = 32'sh8000_0000;
                default: gains[i] = pick_gain();
            endcase
        end
        // Upper bits of the mode word are junk that the block must ignore.
        mode_word      = $urandom;
        mode_word[1:0] = 2'(phase_seq % 4);
        load_settings(mode_word, gains);
        phase_seq++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result word against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        command_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("result word with no prediction waiting");
                fail_count++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (pivot_rate_request !== want.pivot)
                begin
                    $error("pivot_rate_request: expected %0d, got %0d",
                           want.pivot, pivot_rate_request);
                    fail_count++;
                end
                if (wheel_current_request !== want.current)
                begin
                    $error("wheel_current_request: expected %0d, got %0d",
                           want.current, wheel_current_request);
                    fail_count++;
                end
                if (wheel_overspeed_cut !== want.wheel_cut)
                begin
                    $error("wheel_overspeed_cut: expected %0d, got %0d",
                           want.wheel_cut, wheel_overspeed_cut);
                    fail_count++;
                end
                if (gondola_overspeed !== want.gondola_over)
                begin
                    $error("gondola_overspeed: expected %0d, got %0d",
                           want.gondola_over, gondola_overspeed);
                    fail_count++;
                end
                if (invalid_mode !== want.bad_mode)
                begin
                    $error("invalid_mode: expected %0d, got %0d",
                           want.bad_mode, invalid_mode);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A fixed set of words run under each of the four modes: threshold
    // values for both overspeed checks, the wheel cut in both directions,
    // floor rounding of tiny negative products, error saturation and the
    // field extremes.
    task automatic test_directed_cases();
        gain_set_t    gains;
        sensor_word_t cases [7];
        ctrl_mode_t   modes [4];
        modes = '{MODE_POINT, MODE_SPIN, MODE_SCAN, MODE_INVALID};
        gains[CFG_SPIN_WHEEL_ERROR_GAIN] = 32'sd131072;   // 2.0
        gains[CFG_SPIN_WHEEL_ACCEL_GAIN] = 32'sd32768;    // 0.5
        gains[CFG_SPIN_PIVOT_ERROR_GAIN] = 32'sd65536;    // 1.0
        gains[CFG_SPIN_PIVOT_WHEEL_GAIN] = 32'sd655;      // about 0.01
        gains[CFG_SCAN_WHEEL_ERROR_GAIN] = -32'sd98304;   // -1.5
        gains[CFG_SCAN_PIVOT_ERROR_GAIN] = 32'sd196608;   // 3.0
        gains[CFG_SCAN_PIVOT_WHEEL_GAIN] = -32'sd1311;    // about -0.02
        cases[0] = make_word(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        // Positive error on a wheel just past 900 dps: cut in some modes.
        cases[1] = make_word(12 * ONE_DPS, 10 * ONE_DPS, 32'(WHEEL_FAST + 1), 3 * ONE_DPS);
        // Both magnitudes exactly at their thresholds: no overspeed.
        cases[2] = make_word(32'(GONDOLA_FAST), 32'sd0, 32'(-WHEEL_FAST), 32'sh7FFF_FFFF);
        // One LSB past both thresholds, negative wheel.
        cases[3] = make_word(32'(GONDOLA_FAST + 1), -5 * ONE_DPS, 32'(-WHEEL_FAST - 1),
                             32'sh8000_0000);
        // One-LSB negatives: tiny negative products round down to -1 LSB, not to zero.
        cases[4] = make_word(-32'sd1, 32'sd0, -32'sd1, -32'sd1);
        cases[5] = make_word(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        // The error saturates high while the gondola stays in range.
        cases[6] = make_word(30 * ONE_DPS, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_idle_pct = 0;
        stall_pct     = 0;
        foreach (modes[m])
        begin
            wait_idle();
            load_settings(32'(modes[m]), gains);
            foreach (cases[i])
            begin
                send_word(cases[i]);
            end
        end
    endtask

    // Random words over a series of settings at one idling mix.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct_v);
        for (int p = 0; p < 6; p++)
        begin
            next_setting();
            send_idle_pct = idle_pct;
            stall_pct     = stall_pct_v;
            for (int i = 0; i < 42; i++)
            begin
                send_word(random_word());
            end
        end
    endtask

    // The receiver holds off long enough for the pipeline to fill and drop
    // in_ready while words keep coming; then the sender pauses until all
    // results are back.
    task automatic test_output_backpressure();
        for (int r = 0; r < 2; r++)
        begin
            next_setting();
            send_idle_pct = 0;
            stall_pct     = 0;
            hold_req      = 60;
            for (int i = 0; i < 40; i++)
            begin
                send_word(random_word());
            end
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(0, 0);
        test_random_traffic(67, 0);
        test_random_traffic(0, 67);
        test_random_traffic(15, 15);
        test_output_backpressure();

        wait_idle();
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
